// ===== sv/lin_slave_network_manager_core_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef LIN_SLAVE_NETWORK_MANAGER_CORE_MACROS_SVH
`define LIN_SLAVE_NETWORK_MANAGER_CORE_MACROS_SVH

// Concurrent assertion that is ignored while reset is applied.
`define LSNM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is checked during reset as well.
`define LSNM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/lsnm_pkg.sv =====
package lsnm_pkg;

    localparam int TIMER_W = 16;
    localparam int CFG_W   = 16;
    localparam int SUM_W   = ((TIMER_W > CFG_W) ? TIMER_W : CFG_W) + 1;

    typedef logic [TIMER_W-1:0] t_timer;
    typedef logic [CFG_W-1:0]   t_cfg;

    localparam t_timer TMAX = {TIMER_W{1'b1}};

    localparam logic [2:0] ST_PON    = 3'd0;
    localparam logic [2:0] ST_WAIT   = 3'd1;
    localparam logic [2:0] ST_SLEEP  = 3'd2;
    localparam logic [2:0] ST_WAKE   = 3'd3;
    localparam logic [2:0] ST_OTHER  = 3'd4;
    localparam logic [2:0] ST_ACTIVE = 3'd5;

    localparam logic [1:0] ACT_NONE   = 2'd0;
    localparam logic [1:0] ACT_RUN    = 2'd1;
    localparam logic [1:0] ACT_WAKEUP = 2'd2;
    localparam logic [1:0] ACT_SLEEP  = 2'd3;

    localparam logic [1:0] BUS_SLEEP   = 2'd0;
    localparam logic [1:0] BUS_STANDBY = 2'd1;
    localparam logic [1:0] BUS_RUN     = 2'd2;

    localparam logic [1:0] REQ_WAKE   = 2'd0;
    localparam logic [1:0] REQ_SLEEP  = 2'd1;
    localparam logic [1:0] REQ_FORCED = 2'd2;

    localparam logic KIND_TICK = 1'b0;

    localparam logic [2:0] CFG_TIME_BASE   = 3'd0;
    localparam logic [2:0] CFG_STARTUP     = 3'd1;
    localparam logic [2:0] CFG_RETRY_TIME  = 3'd2;
    localparam logic [2:0] CFG_THREE_BREAK = 3'd3;
    localparam logic [2:0] CFG_SLEEP_TO    = 3'd4;
    localparam logic [2:0] CFG_DATA_IND    = 3'd5;
    localparam logic [2:0] CFG_RETRY_CNT   = 3'd6;
    localparam logic [2:0] CFG_MASTER_ERR  = 3'd7;

    localparam logic [7:0] NM_SLEEP_IND = 8'h80;
    localparam logic [7:0] NM_WAKE_IND  = 8'h40;
    localparam logic [7:0] NM_DATA_IND  = 8'h20;
    localparam logic [7:0] NM_RESP_ERR  = 8'h10;

    typedef struct packed {
        logic       kind;
        logic [1:0] bus_status;
        logic [1:0] sleep_request;
        logic       response_error_any;
    } t_in;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] nm_info;
        logic [2:0] slave_state_out;
        logic       master_error;
        logic       system_error;
    } t_out;

    function automatic t_timer f_tadd(input t_timer t, input t_cfg b);
        logic [SUM_W-1:0] s;
        s = SUM_W'(t) + SUM_W'(b);
        return (s > SUM_W'(TMAX)) ? TMAX : t_timer'(s);
    endfunction

    function automatic logic f_ge(input t_timer t, input t_cfg lim);
        return SUM_W'(t) >= SUM_W'(lim);
    endfunction

endpackage

// ===== sv/lin_slave_network_manager_core.sv =====
// Channel  Direction  Handshake        Payload
// in       input      valid / stall    t_in: kind, bus status, sleep request, response error
// out      output     valid / stall    t_out: action, NM info, state, error flags
// cfg      input      valid / ready    3-bit register index, 16-bit data
//
// One transaction per cycle is sustained while the output does not stall; each passes
// from acceptance through the input register and then the result register.
// The state update between them is a single pass of adders and compares.
// Reset restores all state and the register defaults; configuration is always ready.
// A stall on the output stops the input only once both registers are full.
module lin_slave_network_manager_core
    import lsnm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in        i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out       o_out_data,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  t_cfg       i_cfg_data
);

    t_cfg       r_time_base, r_startup_lim, r_retry_time, r_break_lim;
    t_cfg       r_sleep_lim, r_data_lim, r_retry_cnt_lim;
    logic [7:0] r_me_lim;

    logic       r_in_vld, r_out_vld;
    t_in        r_in;
    t_out       r_out;

    logic [2:0] r_state, n_state;
    t_timer     r_st_tmr, n_st_tmr, r_rt_tmr, n_rt_tmr, r_bk_tmr, n_bk_tmr;
    t_timer     r_to_tmr, n_to_tmr, r_dt_tmr, n_dt_tmr;
    t_cfg       r_rt_cnt, n_rt_cnt;
    logic       r_wake_f, n_wake_f, r_data_f, n_data_f, r_me_f, n_me_f, r_se_f, n_se_f;
    logic [7:0] r_me_cnt, n_me_cnt;

    logic       adv;
    logic [1:0] act;
    logic [7:0] info;
    t_timer     to_inc, bk_inc, rt_inc;
    logic       rt_fire, rt_more, bk_done, me_set;
    logic [7:0] me_inc;

    assign adv         = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall  = r_in_vld && !adv;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    assign to_inc  = f_tadd(r_to_tmr, r_time_base);
    assign bk_inc  = f_tadd(r_bk_tmr, r_time_base);
    assign rt_inc  = f_tadd(r_rt_tmr, r_time_base);
    assign rt_fire = f_ge(rt_inc, r_retry_time);
    assign rt_more = r_rt_cnt < r_retry_cnt_lim;
    assign bk_done = f_ge(bk_inc, r_break_lim);
    assign me_inc  = (r_me_cnt == 8'hFF) ? r_me_cnt : r_me_cnt + 8'd1;
    assign me_set  = me_inc >= r_me_lim;

    always_comb begin
        n_state  = r_state;
        n_st_tmr = r_st_tmr;
        n_rt_tmr = r_rt_tmr;
        n_bk_tmr = r_bk_tmr;
        n_to_tmr = r_to_tmr;
        n_dt_tmr = r_dt_tmr;
        n_rt_cnt = r_rt_cnt;
        n_wake_f = r_wake_f;
        n_data_f = r_data_f;
        n_me_cnt = r_me_cnt;
        n_me_f   = r_me_f;
        n_se_f   = r_se_f;
        act      = ACT_NONE;

        if (r_in.kind != KIND_TICK) begin
            n_me_f = 1'b0;
        end else begin
            unique case (r_in.bus_status)
                BUS_SLEEP: begin
                    unique case (r_state)
                        ST_PON: begin
                            n_st_tmr = f_tadd(r_st_tmr, r_time_base);
                            act      = ACT_RUN;
                        end
                        ST_WAIT: begin
                            if (r_in.sleep_request == REQ_SLEEP) begin
                                n_to_tmr = to_inc;
                                if (f_ge(to_inc, r_sleep_lim)) begin
                                    n_state = ST_SLEEP;
                                end
                            end else if (r_in.sleep_request == REQ_WAKE) begin
                                act      = ACT_WAKEUP;
                                n_wake_f = 1'b1;
                                n_rt_tmr = '0;
                                n_rt_cnt = '0;
                                n_to_tmr = '0;
                                n_bk_tmr = '0;
                                n_state  = ST_WAKE;
                            end else if (r_in.sleep_request == REQ_FORCED) begin
                                n_state = ST_SLEEP;
                            end
                        end
                        ST_SLEEP: begin
                            if (r_in.sleep_request == REQ_WAKE) begin
                                act      = ACT_WAKEUP;
                                n_wake_f = 1'b1;
                                n_rt_tmr = '0;
                                n_rt_cnt = '0;
                                n_to_tmr = '0;
                                n_bk_tmr = '0;
                                n_state  = ST_WAKE;
                            end
                        end
                        ST_WAKE: begin
                            n_to_tmr = to_inc;
                            n_bk_tmr = bk_inc;
                            n_rt_tmr = rt_inc;
                            if (rt_fire) begin
                                if (rt_more) begin
                                    act      = ACT_WAKEUP;
                                    n_rt_cnt = r_rt_cnt + t_cfg'(1);
                                    n_rt_tmr = '0;
                                    n_bk_tmr = '0;
                                end else begin
                                    n_state = ST_OTHER;
                                end
                            end
                        end
                        ST_OTHER: begin
                            n_to_tmr = to_inc;
                            n_bk_tmr = bk_inc;
                            if (bk_done) begin
                                n_me_cnt = me_inc;
                                if (me_set) begin
                                    n_me_f = 1'b1;
                                end
                                n_wake_f = 1'b0;
                                n_state  = ST_WAIT;
                            end
                        end
                        default: begin
                            n_wake_f = 1'b0;
                            n_state  = ST_SLEEP;
                        end
                    endcase
                end
                BUS_STANDBY: begin
                    unique case (r_state) inside
                        ST_PON: begin
                            n_to_tmr = to_inc;
                            n_st_tmr = f_tadd(r_st_tmr, r_time_base);
                            if (f_ge(n_st_tmr, r_startup_lim)) begin
                                act     = ACT_SLEEP;
                                n_state = ST_WAIT;
                            end
                        end
                        ST_WAIT, ST_SLEEP: begin
                            n_to_tmr = '0;
                            n_bk_tmr = '0;
                            n_state  = ST_OTHER;
                        end
                        ST_WAKE: begin
                            n_to_tmr = to_inc;
                            n_bk_tmr = bk_inc;
                            n_rt_tmr = rt_inc;
                            if (rt_fire) begin
                                if (rt_more) begin
                                    act      = ACT_WAKEUP;
                                    n_rt_cnt = r_rt_cnt + t_cfg'(1);
                                    n_rt_tmr = '0;
                                    n_bk_tmr = '0;
                                end else begin
                                    n_state = ST_OTHER;
                                end
                            end
                        end
                        ST_OTHER: begin
                            n_to_tmr = to_inc;
                            n_bk_tmr = bk_inc;
                            if (bk_done) begin
                                n_me_cnt = me_inc;
                                if (me_set) begin
                                    n_me_f = 1'b1;
                                end
                                n_wake_f = 1'b0;
                                n_state  = ST_WAIT;
                                act      = ACT_SLEEP;
                            end
                        end
                        default: begin
                            n_wake_f = 1'b0;
                            n_to_tmr = '0;
                            n_bk_tmr = '0;
                            n_state  = ST_OTHER;
                        end
                    endcase
                end
                BUS_RUN: begin
                    if (r_state <= ST_OTHER) begin
                        n_me_cnt = '0;
                        n_me_f   = 1'b0;
                        n_state  = ST_ACTIVE;
                    end else if (r_state == ST_ACTIVE) begin
                        if (r_in.sleep_request == REQ_FORCED) begin
                            act      = ACT_SLEEP;
                            n_wake_f = 1'b0;
                            n_state  = ST_SLEEP;
                        end
                    end else begin
                        n_state = ST_ACTIVE;
                    end
                end
                default: begin
                    n_se_f = 1'b1;
                end
            endcase

            if (!r_data_f) begin
                n_dt_tmr = f_tadd(r_dt_tmr, r_time_base);
                if (f_ge(n_dt_tmr, r_data_lim)) begin
                    n_data_f = 1'b1;
                end
            end
        end

        info = '0;
        if (r_in.response_error_any) begin
            info = info | NM_RESP_ERR;
        end
        if (r_in.sleep_request == REQ_SLEEP) begin
            info = info | NM_SLEEP_IND;
        end
        if (n_wake_f) begin
            info = info | NM_WAKE_IND;
        end
        if (n_data_f) begin
            info = info | NM_DATA_IND;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_base     <= t_cfg'(10);
            r_startup_lim   <= t_cfg'(100);
            r_retry_time    <= t_cfg'(150);
            r_break_lim     <= t_cfg'(1500);
            r_sleep_lim     <= t_cfg'(4000);
            r_data_lim      <= t_cfg'(100);
            r_retry_cnt_lim <= t_cfg'(2);
            r_me_lim        <= 8'd3;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_TIME_BASE:   r_time_base     <= i_cfg_data;
                CFG_STARTUP:     r_startup_lim   <= i_cfg_data;
                CFG_RETRY_TIME:  r_retry_time    <= i_cfg_data;
                CFG_THREE_BREAK: r_break_lim     <= i_cfg_data;
                CFG_SLEEP_TO:    r_sleep_lim     <= i_cfg_data;
                CFG_DATA_IND:    r_data_lim      <= i_cfg_data;
                CFG_RETRY_CNT:   r_retry_cnt_lim <= i_cfg_data;
                CFG_MASTER_ERR:  r_me_lim        <= i_cfg_data[7:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_state   <= ST_PON;
            r_st_tmr  <= '0;
            r_rt_tmr  <= '0;
            r_bk_tmr  <= '0;
            r_to_tmr  <= '0;
            r_dt_tmr  <= '0;
            r_rt_cnt  <= '0;
            r_wake_f  <= 1'b0;
            r_data_f  <= 1'b0;
            r_me_cnt  <= '0;
            r_me_f    <= 1'b0;
            r_se_f    <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_vld <= i_in_valid;
            end
            if (adv) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            if (adv) begin
                r_state  <= n_state;
                r_st_tmr <= n_st_tmr;
                r_rt_tmr <= n_rt_tmr;
                r_bk_tmr <= n_bk_tmr;
                r_to_tmr <= n_to_tmr;
                r_dt_tmr <= n_dt_tmr;
                r_rt_cnt <= n_rt_cnt;
                r_wake_f <= n_wake_f;
                r_data_f <= n_data_f;
                r_me_cnt <= n_me_cnt;
                r_me_f   <= n_me_f;
                r_se_f   <= n_se_f;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (adv) begin
            r_out.action          <= act;
            r_out.nm_info         <= info;
            r_out.slave_state_out <= n_state;
            r_out.master_error    <= n_me_f;
            r_out.system_error    <= n_se_f;
        end
    end

endmodule

// ===== sv/lsnm_checker.sv =====
`include "lin_slave_network_manager_core_macros.svh"

module lsnm_checker
    import lsnm_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input t_out       o_out_data
);

    `LSNM_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data), "Stalled result transaction changed")
    `LSNM_ASSERT(a_in_stall_cause, i_clk, i_rst_n, o_in_stall |-> o_out_valid && i_out_stall, "Input stalled without a blocked result")
    `LSNM_ASSERT(a_state_legal, i_clk, i_rst_n, o_out_valid |-> o_out_data.slave_state_out <= ST_ACTIVE, "Result reports an unused state code")
    `LSNM_ASSERT(a_run_in_pon, i_clk, i_rst_n, o_out_valid && o_out_data.action == ACT_RUN |-> o_out_data.slave_state_out == ST_PON, "Start-run action outside power-on")
    `LSNM_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid, "Result valid right after reset")

endmodule

bind lin_slave_network_manager_core lsnm_checker u_lsnm_checker (.*);
